### rtl/dqr_pkg.sv
// Package for the bounded deque with removal at an index.
// Holds sizes, command and status codes, cell control and the transfer structs.
// No dependencies.
package dqr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      fill_t;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE_AT  = 3'd4,
		CMD_CLEAR      = 3'd5,
		CMD_NOP        = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// What a cell loads at the next edge
	typedef enum logic [1:0] {
		SEL_HOLD  = 2'd0,
		SEL_LOAD  = 2'd1,
		SEL_LEFT  = 2'd2,
		SEL_RIGHT = 2'd3
	} cell_sel_t;

	typedef struct packed {
		cell_sel_t sel;
		logic      is_last;
	} cell_ctrl_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] value;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [31:0] front_word;
		logic [31:0] back_word;
		logic [6:0]  count;
		logic        is_empty;
		status_t     status;
	} rsp_t;

endpackage

### rtl/dqr_cell.sv
// One storage cell of the deque chain: holds a word, loads a new one or shifts from a neighbour.
// Depends on dqr_pkg.
module dqr_cell
	import dqr_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  word_t      load_word,
	input  word_t      from_left,
	input  word_t      from_right,
	output word_t      word,
	output word_t      back_part
);

	word_t word_q;

	// Cell register: hold, new word, or shift from a neighbour
	always_ff @(posedge clk) begin
		case (ctrl.sel)
			SEL_LOAD:  word_q <= load_word;
			SEL_LEFT:  word_q <= from_left;
			SEL_RIGHT: word_q <= from_right;
			default:   word_q <= word_q;
		endcase
	end

	assign word      = word_q;
	// Only the last occupied cell contributes to the back word
	assign back_part = ctrl.is_last ? word_q : '0;

endmodule

### rtl/bounded_deque_remove_at.sv
// Top level of the bounded deque with removal at an index.
// Depends on dqr_pkg and dqr_cell.
//
// Usage:
//   The req channel carries one command per transfer (push front/back, pop
//   front/back, remove at position, clear, nop). The rsp channel returns one
//   result per command: front word, back word, count, empty flag, status.
//   Position 0 is the front of the list.
// Timing:
//   A command is applied to the row of cells at the edge it is accepted; the
//   result is then formed from the updated cells and registered onto rsp.
//   No new command is taken until that result has been loaded: req_stall is
//   high while the result is being formed. All cells shift in parallel, so a
//   push front, pop front or remove takes no longer than a push back.
// Reset:
//   arst_n empties the list and drops rsp_valid; cell contents are not reset
//   and are never shown until written.
// Receiver stall:
//   A result held under rsp_stall stays unchanged. One further command may be
//   accepted meanwhile; req_stall then stays high until the held result has
//   been taken.
module bounded_deque_remove_at
	import dqr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	fill_t      fill_q;
	fill_t      fill_next;
	logic       busy_q;
	status_t    status_q;
	status_t    status_next;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       req_acc;
	logic       rsp_load;
	word_t      in_word;
	fill_t      pos_ext;
	word_t      cell_word [MAX_ENTRIES];
	word_t      cell_back [MAX_ENTRIES];
	cell_ctrl_t cell_ctrl [MAX_ENTRIES];
	word_t      front_w;
	word_t      back_w;

	assign req_stall = busy_q;
	assign req_acc   = req_valid & ~req_stall;
	assign in_word   = DATA_WIDTH'(req.value);
	assign pos_ext   = CNT_W'(req.position);

	// Command decode: new count, status and per-cell load selects
	always_comb begin
		fill_next   = fill_q;
		status_next = ST_OK;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			cell_ctrl[i].sel     = SEL_HOLD;
			cell_ctrl[i].is_last = (fill_q == CNT_W'(i + 1));
		end
		if (req_acc) begin
			case (req.command)
				CMD_PUSH_FRONT: begin
					if (fill_q == CNT_W'(MAX_ENTRIES)) begin
						status_next = ST_FULL;
					end else begin
						fill_next = fill_q + 1'b1;
						for (int i = 0; i < MAX_ENTRIES; i++)
							cell_ctrl[i].sel = SEL_LEFT;
					end
				end
				CMD_PUSH_BACK: begin
					if (fill_q == CNT_W'(MAX_ENTRIES)) begin
						status_next = ST_FULL;
					end else begin
						fill_next = fill_q + 1'b1;
						for (int i = 0; i < MAX_ENTRIES; i++)
							if (fill_q == CNT_W'(i))
								cell_ctrl[i].sel = SEL_LOAD;
					end
				end
				CMD_POP_FRONT: begin
					if (fill_q == '0) begin
						status_next = ST_EMPTY;
					end else begin
						fill_next = fill_q - 1'b1;
						for (int i = 0; i < MAX_ENTRIES; i++)
							cell_ctrl[i].sel = SEL_RIGHT;
					end
				end
				CMD_POP_BACK: begin
					if (fill_q == '0)
						status_next = ST_EMPTY;
					else
						fill_next = fill_q - 1'b1;
				end
				CMD_REMOVE_AT: begin
					if (pos_ext >= fill_q) begin
						status_next = ST_RANGE;
					end else begin
						fill_next = fill_q - 1'b1;
						for (int i = 0; i < MAX_ENTRIES; i++)
							if (CNT_W'(i) >= pos_ext)
								cell_ctrl[i].sel = SEL_RIGHT;
					end
				end
				CMD_CLEAR: fill_next = '0;
				default:   fill_next = fill_q;
			endcase
		end
	end

	// Row of cells; the word enters at cell 0 for a push front
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		dqr_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[g]),
			.load_word  (in_word),
			.from_left  ((g == 0) ? in_word : cell_word[(g == 0) ? 0 : g - 1]),
			.from_right ((g == MAX_ENTRIES - 1) ? word_t'('0)
			             : cell_word[(g == MAX_ENTRIES - 1) ? g : g + 1]),
			.word       (cell_word[g]),
			.back_part  (cell_back[g])
		);
	end

	// Front and back words from the updated cells
	always_comb begin
		front_w = (fill_q == '0) ? '0 : cell_word[0];
		back_w  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++)
			back_w = back_w | cell_back[i];
	end

	assign rsp_load = busy_q & (~rsp_valid_q | ~rsp_stall);

	// Count, pending flag and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_next;
			if (req_acc)
				busy_q <= 1'b1;
			else if (rsp_load)
				busy_q <= 1'b0;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (~rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	// Status of the command in flight and the response register
	always_ff @(posedge clk) begin
		if (req_acc)
			status_q <= status_next;
		if (rsp_load) begin
			rsp_q.front_word <= 32'(front_w);
			rsp_q.back_word  <= 32'(back_w);
			rsp_q.count      <= 7'(fill_q);
			rsp_q.is_empty   <= (fill_q == '0);
			rsp_q.status     <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ENTRIES))
		else $error("fill count above capacity");

	a_acc_pending: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> busy_q)
		else $error("accepted command not pending");

	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |-> rsp.front_word == '0 && rsp.back_word == '0
			&& rsp.count == '0)
		else $error("empty result carries data");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.count == 7'(MAX_ENTRIES))
		else $error("push refused while not full");

endmodule
